FILE: design/c2s_pkg.sv
// ---------------------------------------------------------------------------
// c2s_pkg
// Shared widths, field offsets and the arctangent table of the Cartesian to
// spherical converter.
// ---------------------------------------------------------------------------
package c2s_pkg;

	localparam int COMP_BITS    = 18;
	localparam int ANGLE_BITS   = 16;
	localparam int Q_BITS       = 16;
	localparam int CORDIC_STEPS = 28;
	localparam int NORM_STEPS   = 5;

	// |x| <= 2^(COMP_BITS-1), so a square needs 2*COMP_BITS-1 bits
	localparam int SQ_W   = 2 * COMP_BITS - 1;
	localparam int SUM_W  = 2 * COMP_BITS;
	localparam int RAD_W  = 62;
	localparam int ROOT_W = RAD_W / 2;
	localparam int NRM_W  = 31;
	localparam int ACC_W  = 32;
	localparam int CW     = 36;

	localparam int IN_W       = ((3 * COMP_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_W = COMP_BITS + 2 * ANGLE_BITS + 2 * Q_BITS;
	localparam int OUT_W      = ((OUT_DATA_W + 7) / 8) * 8;

	localparam int X_LO   = 0;
	localparam int Y_LO   = COMP_BITS;
	localparam int Z_LO   = 2 * COMP_BITS;
	localparam int MAG_LO = 0;
	localparam int AZ_LO  = COMP_BITS;
	localparam int POL_LO = AZ_LO + ANGLE_BITS;
	localparam int CP_LO  = POL_LO + ANGLE_BITS;
	localparam int CA_LO  = CP_LO + Q_BITS;

	localparam int PRE_LAT    = 3 + NORM_STEPS;
	localparam int SQRT_LAT   = ROOT_W;
	localparam int CORDIC_LAT = CORDIC_STEPS + 1;
	localparam int DIV_LAT    = Q_BITS;
	localparam int PIPE_LAT   = PRE_LAT + SQRT_LAT + CORDIC_LAT + 1;

	localparam logic [Q_BITS-1:0] COS_MAX = {1'b0, {(Q_BITS-1){1'b1}}};

	// atan(2^-i) with 2^32 units per turn
	function automatic logic [ACC_W-1:0] atan_val(input int idx);
		logic [ACC_W-1:0] v;
		case (idx)
			0:  v = 32'd536870912;
			1:  v = 32'd316933406;
			2:  v = 32'd167458907;
			3:  v = 32'd85004756;
			4:  v = 32'd42667331;
			5:  v = 32'd21354465;
			6:  v = 32'd10679838;
			7:  v = 32'd5340245;
			8:  v = 32'd2670163;
			9:  v = 32'd1335087;
			10: v = 32'd667544;
			11: v = 32'd333772;
			12: v = 32'd166886;
			13: v = 32'd83443;
			14: v = 32'd41722;
			15: v = 32'd20861;
			16: v = 32'd10430;
			17: v = 32'd5215;
			18: v = 32'd2608;
			19: v = 32'd1304;
			20: v = 32'd652;
			21: v = 32'd326;
			22: v = 32'd163;
			23: v = 32'd81;
			24: v = 32'd41;
			25: v = 32'd20;
			26: v = 32'd10;
			27: v = 32'd5;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

FILE: design/c2s_isqrt.sv
// ---------------------------------------------------------------------------
// c2s_isqrt
// Pipelined integer square root, one root bit per stage, rounded down.
// ---------------------------------------------------------------------------
module c2s_isqrt import c2s_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [RAD_W-1:0]  rad,
	output logic [ROOT_W-1:0] root
);

	localparam int REM_W = ROOT_W + 3;

	logic [REM_W-1:0]  rem_s  [0:ROOT_W-1];
	logic [ROOT_W-1:0] root_s [0:ROOT_W-1];
	logic [RAD_W-1:0]  rad_s  [0:ROOT_W-2];

	for (genvar g = 0; g < ROOT_W; g++) begin : g_st
		logic [REM_W-1:0]  rem_in, rem_try, trial;
		logic [ROOT_W-1:0] root_in;
		logic [RAD_W-1:0]  rad_in;

		if (g == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = rad;
		end else begin : g_next
			assign rem_in  = rem_s[g-1];
			assign root_in = root_s[g-1];
			assign rad_in  = rad_s[g-1];
		end

		// bring down the next two radicand bits
		assign rem_try = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
		assign trial   = REM_W'({root_in, 2'b01});

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_try >= trial) begin
					rem_s[g]  <= rem_try - trial;
					root_s[g] <= {root_in[ROOT_W-2:0], 1'b1};
				end else begin
					rem_s[g]  <= rem_try;
					root_s[g] <= {root_in[ROOT_W-2:0], 1'b0};
				end
			end
		end

		if (g < ROOT_W - 1) begin : g_rad
			always_ff @(posedge clk) begin
				if (en) begin
					rad_s[g] <= rad_in << 2;
				end
			end
		end
	end

	assign root = root_s[ROOT_W-1];

endmodule

FILE: design/c2s_cosdiv.sv
// ---------------------------------------------------------------------------
// c2s_cosdiv
// Pipelined num/sqrt(den2) in Q1.15, truncated: largest q with
// q^2*den2 <= num^2*2^30, one quotient bit per stage.
// ---------------------------------------------------------------------------
module c2s_cosdiv import c2s_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [SQ_W-1:0]   n2,
	input  logic [SUM_W-1:0]  den2,
	output logic [Q_BITS-1:0] q
);

	localparam int R_W = SQ_W + 2 * (Q_BITS - 1) + 1;
	localparam int D_W = SUM_W + Q_BITS;
	localparam int T_W = SUM_W + 2 * Q_BITS + 2;

	// r: what is left of num^2*2^30 - q^2*den2, d: q*den2
	logic [R_W-1:0]    r_s   [0:Q_BITS-2];
	logic [D_W-1:0]    d_s   [0:Q_BITS-2];
	logic [SUM_W-1:0]  den_s [0:Q_BITS-2];
	logic [Q_BITS-1:0] q_s   [0:Q_BITS-1];

	for (genvar g = 0; g < Q_BITS; g++) begin : g_st
		localparam int B = Q_BITS - 1 - g;
		logic [R_W-1:0]    r_in;
		logic [D_W-1:0]    d_in;
		logic [SUM_W-1:0]  den_in;
		logic [Q_BITS-1:0] q_in;
		logic [T_W-1:0]    t_val;
		logic              take;

		if (g == 0) begin : g_first
			assign r_in   = R_W'(n2) << (2 * (Q_BITS - 1));
			assign d_in   = '0;
			assign den_in = den2;
			assign q_in   = '0;
		end else begin : g_next
			assign r_in   = r_s[g-1];
			assign d_in   = d_s[g-1];
			assign den_in = den_s[g-1];
			assign q_in   = q_s[g-1];
		end

		// (q + 2^B)^2*den2 - q^2*den2
		assign t_val = (T_W'(d_in) << (B + 1)) + (T_W'(den_in) << (2 * B));
		assign take  = t_val <= T_W'(r_in);

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[g] <= take ? (q_in | (Q_BITS'(1) << B)) : q_in;
			end
		end

		if (g < Q_BITS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					r_s[g]   <= take ? r_in - R_W'(t_val) : r_in;
					d_s[g]   <= take ? d_in + (D_W'(den_in) << B) : d_in;
					den_s[g] <= den_in;
				end
			end
		end
	end

	assign q = q_s[Q_BITS-1];

endmodule

FILE: design/c2s_cordic.sv
// ---------------------------------------------------------------------------
// c2s_cordic
// Pipelined vectoring CORDIC: atan2(b, a) with 2^32 units per turn.
// One half-turn fold stage, then one micro-rotation per stage.
// ---------------------------------------------------------------------------
module c2s_cordic import c2s_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [CW-1:0] a_in,
	input  logic signed [CW-1:0] b_in,
	output logic [ACC_W-1:0]     ang
);

	logic signed [CW-1:0] a_s   [0:CORDIC_STEPS];
	logic signed [CW-1:0] b_s   [0:CORDIC_STEPS];
	logic [ACC_W-1:0]     ang_s [0:CORDIC_STEPS];

	// fold the left half-plane onto the right one
	always_ff @(posedge clk) begin
		if (en) begin
			if (a_in[CW-1]) begin
				a_s[0]   <= -a_in;
				b_s[0]   <= -b_in;
				ang_s[0] <= ACC_W'(1) << (ACC_W - 1);
			end else begin
				a_s[0]   <= a_in;
				b_s[0]   <= b_in;
				ang_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
		always_ff @(posedge clk) begin
			if (en) begin
				if (!b_s[i][CW-1]) begin
					a_s[i+1]   <= a_s[i] + (b_s[i] >>> i);
					b_s[i+1]   <= b_s[i] - (a_s[i] >>> i);
					ang_s[i+1] <= ang_s[i] + atan_val(i);
				end else begin
					a_s[i+1]   <= a_s[i] - (b_s[i] >>> i);
					b_s[i+1]   <= b_s[i] + (a_s[i] >>> i);
					ang_s[i+1] <= ang_s[i] - atan_val(i);
				end
			end
		end
	end

	assign ang = ang_s[CORDIC_STEPS];

endmodule

FILE: design/cartesian_to_spherical_top.sv
// ---------------------------------------------------------------------------
// cartesian_to_spherical_top
// Throughput: one word per cycle while the output buffer is empty; the 31-stage
// square roots and the 29-stage CORDICs are fully pipelined. A one-word output
// buffer takes the last word on a sink stall; the pipeline and s_tready hold
// until that word drains.
// Reset (arst_n low, asynchronous) clears all valid bits and the buffer.
// ---------------------------------------------------------------------------
module cartesian_to_spherical_top import c2s_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // comp_x, comp_y, comp_z, zero pad
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,  // magnitude, azimuth, polar, cos_polar,
	                                   // cos_azimuth, zero pad
	output logic             m_tuser   // zero_vector
);

	typedef struct packed {
		logic [SUM_W-1:0] s;
		logic [SUM_W-1:0] r2;
		logic [SQ_W-1:0]  xx;
		logic [SQ_W-1:0]  zz;
		logic             zero;
		logic             xneg;
		logic             zneg;
	} base_t;

	typedef struct packed {
		base_t             b;
		logic [RAD_W-1:0]  r2s;
		logic [NRM_W-1:0]  zm;
		logic [NRM_W:0]    zs;
		logic [NRM_W-1:0]  mm;
		logic [NRM_W:0]    xa;
		logic [NRM_W:0]    ya;
	} nrm_t;

	typedef struct packed {
		base_t          b;
		logic [NRM_W:0] zs;
		logic [NRM_W:0] xa;
		logic [NRM_W:0] ya;
	} mid_t;

	typedef struct packed {
		logic                 zero;
		logic                 az_ok;
		logic                 xneg;
		logic                 zneg;
		logic [COMP_BITS-1:0] mag;
	} tail_t;

	typedef struct packed {
		logic [Q_BITS-1:0] qa;
		logic [Q_BITS-1:0] qp;
	} cq_t;

	logic en;
	logic vld_s [0:PIPE_LAT-1];

	logic signed [COMP_BITS-1:0] x_s1, y_s1, z_s1;
	logic signed [COMP_BITS-1:0] x_s2, y_s2, z_s2;
	logic [COMP_BITS-1:0]        ax_s2, ay_s2, az_s2;
	logic [SQ_W-1:0]             xx_s2, yy_s2, zz_s2;
	logic                        zero_s2;
	logic [COMP_BITS-1:0]        ax, ay, az;

	nrm_t  nrm_s  [0:NORM_STEPS];
	mid_t  mid_s  [0:SQRT_LAT-1];
	tail_t tail_s [0:CORDIC_LAT-1];
	cq_t   cq_s   [0:CORDIC_LAT-DIV_LAT-1];

	logic [ROOT_W-1:0] rho, mag_root;
	logic [ACC_W-1:0]  az_ang, pol_ang, pol_clip;
	logic [Q_BITS-1:0] qa, qp;
	logic [ACC_W:0]    az_sum, pol_sum;
	logic [OUT_W-1:0]  res_data, res_s69, skid_data_q;
	logic              res_user, res_user_s69, skid_user_q, skid_vld_q;
	mid_t              mid_a;
	tail_t             tail_f;

	function automatic logic [Q_BITS-1:0] cos_fmt(input logic [Q_BITS-1:0] q,
	                                              input logic neg);
		if (neg) begin
			return -q;
		end
		return q[Q_BITS-1] ? COS_MAX : q;
	endfunction

	assign en       = !skid_vld_q;
	assign s_tready = en;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PIPE_LAT; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= s_tvalid;
			for (int i = 1; i < PIPE_LAT; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	// input capture and squares
	assign ax = x_s1[COMP_BITS-1] ? COMP_BITS'(-x_s1) : COMP_BITS'(x_s1);
	assign ay = y_s1[COMP_BITS-1] ? COMP_BITS'(-y_s1) : COMP_BITS'(y_s1);
	assign az = z_s1[COMP_BITS-1] ? COMP_BITS'(-z_s1) : COMP_BITS'(z_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= s_tdata[X_LO +: COMP_BITS];
			y_s1    <= s_tdata[Y_LO +: COMP_BITS];
			z_s1    <= s_tdata[Z_LO +: COMP_BITS];
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			z_s2    <= z_s1;
			ax_s2   <= ax;
			ay_s2   <= ay;
			az_s2   <= az;
			xx_s2   <= SQ_W'(ax * ax);
			yy_s2   <= SQ_W'(ay * ay);
			zz_s2   <= SQ_W'(az * az);
			zero_s2 <= (x_s1 == '0) && (y_s1 == '0) && (z_s1 == '0);
		end
	end

	// sums and start of normalization
	always_ff @(posedge clk) begin
		if (en) begin
			nrm_s[0].b.r2   <= SUM_W'(xx_s2) + SUM_W'(yy_s2);
			nrm_s[0].b.s    <= SUM_W'(xx_s2) + SUM_W'(yy_s2) + SUM_W'(zz_s2);
			nrm_s[0].b.xx   <= xx_s2;
			nrm_s[0].b.zz   <= zz_s2;
			nrm_s[0].b.zero <= zero_s2;
			nrm_s[0].b.xneg <= x_s2[COMP_BITS-1];
			nrm_s[0].b.zneg <= z_s2[COMP_BITS-1];
			nrm_s[0].r2s    <= RAD_W'(xx_s2) + RAD_W'(yy_s2);
			nrm_s[0].zm     <= NRM_W'(az_s2);
			nrm_s[0].zs     <= (NRM_W+1)'(z_s2);
			nrm_s[0].mm     <= NRM_W'(ax_s2 | ay_s2);
			nrm_s[0].xa     <= (NRM_W+1)'(x_s2);
			nrm_s[0].ya     <= (NRM_W+1)'(y_s2);
		end
	end

	// binary-step normalization: scale each operand pair while it stays below 2^31
	for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
		localparam int T = 1 << (NORM_STEPS - 1 - j);
		logic kgo, ngo;

		assign kgo = ((nrm_s[j].r2s >> (RAD_W - 2 * T)) == '0) &&
		             ((nrm_s[j].zm >> (NRM_W - T)) == '0);
		assign ngo = (nrm_s[j].mm >> (NRM_W - T)) == '0;

		always_ff @(posedge clk) begin
			if (en) begin
				nrm_s[j+1].b   <= nrm_s[j].b;
				nrm_s[j+1].r2s <= kgo ? nrm_s[j].r2s << (2 * T) : nrm_s[j].r2s;
				nrm_s[j+1].zm  <= kgo ? nrm_s[j].zm << T : nrm_s[j].zm;
				nrm_s[j+1].zs  <= kgo ? nrm_s[j].zs << T : nrm_s[j].zs;
				nrm_s[j+1].mm  <= ngo ? nrm_s[j].mm << T : nrm_s[j].mm;
				nrm_s[j+1].xa  <= ngo ? nrm_s[j].xa << T : nrm_s[j].xa;
				nrm_s[j+1].ya  <= ngo ? nrm_s[j].ya << T : nrm_s[j].ya;
			end
		end
	end

	c2s_isqrt u_rho (
		.clk  (clk),
		.en   (en),
		.rad  (nrm_s[NORM_STEPS].r2s),
		.root (rho)
	);

	c2s_isqrt u_mag (
		.clk  (clk),
		.en   (en),
		.rad  (RAD_W'(nrm_s[NORM_STEPS].b.s)),
		.root (mag_root)
	);

	// hold operands across the square roots
	always_ff @(posedge clk) begin
		if (en) begin
			mid_s[0].b  <= nrm_s[NORM_STEPS].b;
			mid_s[0].zs <= nrm_s[NORM_STEPS].zs;
			mid_s[0].xa <= nrm_s[NORM_STEPS].xa;
			mid_s[0].ya <= nrm_s[NORM_STEPS].ya;
			for (int i = 1; i < SQRT_LAT; i++) begin
				mid_s[i] <= mid_s[i-1];
			end
		end
	end

	assign mid_a = mid_s[SQRT_LAT-1];

	c2s_cordic u_az (
		.clk  (clk),
		.en   (en),
		.a_in (CW'($signed(mid_a.xa))),
		.b_in (CW'($signed(mid_a.ya))),
		.ang  (az_ang)
	);

	c2s_cordic u_pol (
		.clk  (clk),
		.en   (en),
		.a_in (CW'($signed(mid_a.zs))),
		.b_in (CW'(rho)),
		.ang  (pol_ang)
	);

	c2s_cosdiv u_cos_az (
		.clk  (clk),
		.en   (en),
		.n2   (mid_a.b.xx),
		.den2 (mid_a.b.r2),
		.q    (qa)
	);

	c2s_cosdiv u_cos_pol (
		.clk  (clk),
		.en   (en),
		.n2   (mid_a.b.zz),
		.den2 (mid_a.b.s),
		.q    (qp)
	);

	// align flags, magnitude and cosines with the CORDIC outputs
	always_ff @(posedge clk) begin
		if (en) begin
			tail_s[0].zero  <= mid_a.b.zero;
			tail_s[0].az_ok <= mid_a.b.r2 != '0;
			tail_s[0].xneg  <= mid_a.b.xneg;
			tail_s[0].zneg  <= mid_a.b.zneg;
			tail_s[0].mag   <= COMP_BITS'(mag_root);
			for (int i = 1; i < CORDIC_LAT; i++) begin
				tail_s[i] <= tail_s[i-1];
			end
			cq_s[0].qa <= qa;
			cq_s[0].qp <= qp;
			for (int i = 1; i < CORDIC_LAT - DIV_LAT; i++) begin
				cq_s[i] <= cq_s[i-1];
			end
		end
	end

	assign tail_f = tail_s[CORDIC_LAT-1];

	// clamp polar residue into [0, pi], then round both angles
	always_comb begin
		if (pol_ang[ACC_W-1:ACC_W-2] == 2'b11) begin
			pol_clip = '0;
		end else if (pol_ang > (ACC_W'(1) << (ACC_W - 1))) begin
			pol_clip = ACC_W'(1) << (ACC_W - 1);
		end else begin
			pol_clip = pol_ang;
		end
	end

	assign az_sum  = (ACC_W+1)'(az_ang) + ((ACC_W+1)'(1) << (ACC_W - 1 - ANGLE_BITS));
	assign pol_sum = (ACC_W+1)'(pol_clip) + ((ACC_W+1)'(1) << (ACC_W - 1 - ANGLE_BITS));

	always_comb begin
		res_data = '0;
		res_user = tail_f.zero;
		if (!tail_f.zero) begin
			res_data[MAG_LO +: COMP_BITS] = tail_f.mag;
			res_data[AZ_LO +: ANGLE_BITS] = tail_f.az_ok ?
				az_sum[ACC_W-ANGLE_BITS +: ANGLE_BITS] : '0;
			res_data[POL_LO +: ANGLE_BITS] = pol_sum[ACC_W-ANGLE_BITS +: ANGLE_BITS];
			res_data[CP_LO +: Q_BITS] = cos_fmt(cq_s[CORDIC_LAT-DIV_LAT-1].qp,
			                                    tail_f.zneg);
			res_data[CA_LO +: Q_BITS] = tail_f.az_ok ?
				cos_fmt(cq_s[CORDIC_LAT-DIV_LAT-1].qa, tail_f.xneg) : COS_MAX;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s69      <= res_data;
			res_user_s69 <= res_user;
		end
	end

	// output buffer: take the last stage's word when the sink stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (m_tready) begin
				skid_vld_q <= 1'b0;
			end
		end else if (vld_s[PIPE_LAT-1] && !m_tready) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_vld_q) begin
			skid_data_q <= res_s69;
			skid_user_q <= res_user_s69;
		end
	end

	assign m_tvalid = skid_vld_q | vld_s[PIPE_LAT-1];
	assign m_tdata  = skid_vld_q ? skid_data_q : res_s69;
	assign m_tuser  = skid_vld_q ? skid_user_q : res_user_s69;

endmodule

FILE: design/c2s_checker.sv
// ---------------------------------------------------------------------------
// c2s_checker
// Port-level checks of the converter's output stream.
// ---------------------------------------------------------------------------
module c2s_checker import c2s_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic             m_tuser
);

	// hold a stalled word
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	a_zero_clear: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[OUT_DATA_W-1:0] == '0)
		else $error("zero vector with nonzero fields");

	a_mag_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[MAG_LO +: COMP_BITS] != '0)
		else $error("nonzero vector with zero magnitude");

	a_polar_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[POL_LO +: ANGLE_BITS] <=
		             (ANGLE_BITS'(1) << (ANGLE_BITS - 1)))
		else $error("polar angle beyond pi");

endmodule

bind cartesian_to_spherical_top c2s_checker u_c2s_checker (.*);
